// File: src/lsmr_pkg.sv
// shared constants for the lidar sector minimum range unit
package lsmr_pkg;

    localparam int unsigned RANGE_W = 16;
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_OFFSET  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_CEILING = 3'd4;

    localparam logic [ANGLE_W-1:0] START_ANGLE_RST  = 16'h8000;
    localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST   = 16'd182;
    localparam logic [ANGLE_W-1:0] FRONT_OFFSET_RST = 16'd0;
    localparam logic [RANGE_W-1:0] RANGE_FLOOR_RST  = 16'd0;
    localparam logic [RANGE_W-1:0] RANGE_FULL_SCALE = 16'hFFFF;

    localparam logic signed [ANGLE_W-1:0] SECTOR_30DEG = 16'sd5461;
    localparam logic signed [ANGLE_W-1:0] SECTOR_90DEG = 16'sd16384;

    typedef enum logic [2:0] {
        HIT_FRONT = 3'b001,
        HIT_LEFT  = 3'b010,
        HIT_RIGHT = 3'b100,
        HIT_NONE  = 3'b000
    } t_sector;

endpackage

// File: src/lsmr_if.sv
// sample and result channel interfaces
interface lsmr_in_if
    import lsmr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_mm;
    logic               reading_bad;
    logic               scan_end;

    modport source (output valid, output range_mm, output reading_bad, output scan_end,
                    input ready);
    modport sink   (input valid, input range_mm, input reading_bad, input scan_end,
                    output ready);
endinterface

interface lsmr_out_if
    import lsmr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] front_min_mm;
    logic [RANGE_W-1:0] left_min_mm;
    logic [RANGE_W-1:0] right_min_mm;
    logic               front_hit;
    logic               left_hit;
    logic               right_hit;
    logic               scan_valid;

    modport source (output valid, output front_min_mm, output left_min_mm,
                    output right_min_mm, output front_hit, output left_hit,
                    output right_hit, output scan_valid, input ready);
    modport sink   (input valid, input front_min_mm, input left_min_mm,
                    input right_min_mm, input front_hit, input left_hit,
                    input right_hit, input scan_valid, output ready);
endinterface

// File: src/lidar_sector_min_range_unit.sv
// lidar sector minimum range unit: per-sector minimum over one scan
// result: a scan's result is registered on o_out at the same edge at which its scan_end
//   sample leaves the input register
// throughput: one sample per cycle, set by the combinational angle add and sector compare;
//   input stalls only while a scan_end sample waits behind an unaccepted result
// reset: synchronous active low; registers to defaults, accumulators cleared, no result held
module lidar_sector_min_range_unit
    import lsmr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lsmr_in_if.sink               i_in,
    lsmr_out_if.source            o_out
);

    logic [ANGLE_W-1:0] r_start_angle;
    logic [ANGLE_W-1:0] r_angle_step;
    logic [ANGLE_W-1:0] r_front_offset;
    logic [RANGE_W-1:0] r_range_floor;
    logic [RANGE_W-1:0] r_range_ceiling;

    logic               r_start_pending;
    logic [ANGLE_W-1:0] r_sample_angle;
    logic [ANGLE_W-1:0] n_sample_angle;

    logic               r_s1_valid;
    logic [RANGE_W-1:0] r_s1_range;
    logic               r_s1_bad;
    logic               r_s1_last;

    logic [RANGE_W-1:0] r_front_best;
    logic [RANGE_W-1:0] r_left_best;
    logic [RANGE_W-1:0] r_right_best;
    logic [2:0]         r_hits;
    logic [RANGE_W-1:0] n_front_best;
    logic [RANGE_W-1:0] n_left_best;
    logic [RANGE_W-1:0] n_right_best;
    logic [2:0]         n_hits;

    logic               r_out_valid;
    logic [RANGE_W-1:0] r_out_front;
    logic [RANGE_W-1:0] r_out_left;
    logic [RANGE_W-1:0] r_out_right;
    logic [2:0]         r_out_hits;

    logic                      w_in_xfer;
    logic                      w_s1_adv;
    logic                      w_in_range;
    logic signed [ANGLE_W-1:0] w_angle;
    t_sector                   w_sector;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle   <= START_ANGLE_RST;
            r_angle_step    <= ANGLE_STEP_RST;
            r_front_offset  <= FRONT_OFFSET_RST;
            r_range_floor   <= RANGE_FLOOR_RST;
            r_range_ceiling <= RANGE_FULL_SCALE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_ANGLE:   r_start_angle   <= i_cfg_data;
                CFG_ANGLE_STEP:    r_angle_step    <= i_cfg_data;
                CFG_FRONT_OFFSET:  r_front_offset  <= i_cfg_data;
                CFG_RANGE_FLOOR:   r_range_floor   <= i_cfg_data;
                CFG_RANGE_CEILING: r_range_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshake
    assign w_s1_adv   = !(r_s1_last && r_out_valid && !o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    // stage 1: angle of the sample
    assign n_sample_angle = r_start_pending ? r_start_angle : r_sample_angle + r_angle_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pending <= 1'b1;
            r_sample_angle  <= '0;
            r_s1_valid      <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_start_pending <= i_in.scan_end;
                r_sample_angle  <= n_sample_angle;
                r_s1_valid      <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_range <= i_in.range_mm;
            r_s1_bad   <= i_in.reading_bad;
            r_s1_last  <= i_in.scan_end;
        end
    end

    // stage 2: sector select and minimum update
    assign w_in_range = !r_s1_bad && (r_s1_range >= r_range_floor)
                        && (r_s1_range <= r_range_ceiling);
    assign w_angle    = $signed(r_sample_angle - r_front_offset);

    always_comb begin
        w_sector = HIT_NONE;
        if (w_in_range) begin
            priority if (w_angle >= -SECTOR_30DEG && w_angle <= SECTOR_30DEG) begin
                w_sector = HIT_FRONT;
            end else if (w_angle >= SECTOR_30DEG && w_angle <= SECTOR_90DEG) begin
                w_sector = HIT_LEFT;
            end else if (w_angle >= -SECTOR_90DEG && w_angle <= -SECTOR_30DEG) begin
                w_sector = HIT_RIGHT;
            end else begin
                w_sector = HIT_NONE;
            end
        end
    end

    always_comb begin
        n_front_best = r_front_best;
        n_left_best  = r_left_best;
        n_right_best = r_right_best;
        n_hits       = r_hits | w_sector;
        unique case (w_sector)
            HIT_FRONT: if (r_s1_range < r_front_best) n_front_best = r_s1_range;
            HIT_LEFT:  if (r_s1_range < r_left_best)  n_left_best  = r_s1_range;
            HIT_RIGHT: if (r_s1_range < r_right_best) n_right_best = r_s1_range;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_best <= RANGE_FULL_SCALE;
            r_left_best  <= RANGE_FULL_SCALE;
            r_right_best <= RANGE_FULL_SCALE;
            r_hits       <= '0;
        end else if (r_s1_valid && w_s1_adv) begin
            if (r_s1_last) begin
                r_front_best <= RANGE_FULL_SCALE;
                r_left_best  <= RANGE_FULL_SCALE;
                r_right_best <= RANGE_FULL_SCALE;
                r_hits       <= '0;
            end else begin
                r_front_best <= n_front_best;
                r_left_best  <= n_left_best;
                r_right_best <= n_right_best;
                r_hits       <= n_hits;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && r_s1_last && w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_last && w_s1_adv) begin
            r_out_front <= n_front_best;
            r_out_left  <= n_left_best;
            r_out_right <= n_right_best;
            r_out_hits  <= n_hits;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.front_min_mm = r_out_front;
    assign o_out.left_min_mm  = r_out_left;
    assign o_out.right_min_mm = r_out_right;
    assign o_out.front_hit    = r_out_hits[0];
    assign o_out.left_hit     = r_out_hits[1];
    assign o_out.right_hit    = r_out_hits[2];
    assign o_out.scan_valid   = |r_out_hits;

    // checks
    a_no_hit_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_hits[0]) |-> (r_out_front == RANGE_FULL_SCALE))
        else $error("front minimum set without a hit");

    a_idle_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last && w_s1_adv)
            |=> (r_hits == '0 && r_front_best == RANGE_FULL_SCALE))
        else $error("accumulators not cleared after scan end");

    a_scan_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in.scan_end) |=> r_start_pending)
        else $error("next scan does not restart at start angle");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_range) && $stable(r_s1_last)))
        else $error("stalled sample lost");

endmodule
